// ----- hdl/utf8_to_utf16_decoder_macros.svh -----
// Assertion macros shared by the utf8_to_utf16_decoder RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef UTF8_TO_UTF16_DECODER_MACROS_SVH
`define UTF8_TO_UTF16_DECODER_MACROS_SVH

// same-cycle implication, checked out of reset
`define U2U_ASSERT_IMPLIES(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("u2u assertion failed");

// next-cycle implication, checked out of reset
`define U2U_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("u2u assertion failed");

`endif

// ----- hdl/u2u_pkg.sv -----
// Package for the utf8_to_utf16_decoder: status codes, byte classes,
// the job record passed from the decode front end to the output back end.
package u2u_pkg;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [7:0]  BYTE_CONT_BASE = 8'h80;
   localparam logic [7:0]  BYTE_LEAD2     = 8'hC0;
   localparam logic [7:0]  BYTE_LEAD3     = 8'hE0;
   localparam logic [7:0]  BYTE_LEAD4     = 8'hF0;
   localparam logic [7:0]  BYTE_ILLEGAL   = 8'hF8;

   localparam logic [20:0] SUPP_BASE  = 21'h10000;
   localparam logic [15:0] SURR_HIGH  = 16'hD800;
   localparam logic [15:0] SURR_LOW   = 16'hDC00;

   typedef enum logic [1:0] {
      STATUS_UNIT = 2'd0,
      STATUS_END  = 2'd1,
      STATUS_ERR  = 2'd2
   } status_type;

   // one decoded transaction; a pair sends unit_first then unit_second
   typedef struct packed {
      status_type  status;
      logic        pair;
      logic [15:0] unit_first;
      logic [15:0] unit_second;
   } job_type;

endpackage

// ----- hdl/u2u_front.sv -----
// Decode front end of the utf8_to_utf16_decoder: accepts bytes, tracks
// sequence state and builds one job per result-producing byte. Uses u2u_pkg.
module u2u_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [7:0]       in_byte,
   output logic             job_valid,
   output u2u_pkg::job_type job
);

   logic [1:0]  bytes_left_ff, bytes_left_in;
   logic [20:0] accum_ff, accum_in;
   logic        discarding_ff, discarding_in;

   logic [20:0] offset;

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_left_ff <= '0;
         accum_ff      <= '0;
         discarding_ff <= 1'b0;
      end else if (accept) begin
         bytes_left_ff <= bytes_left_in;
         accum_ff      <= accum_in;
         discarding_ff <= discarding_in;
      end
   end

   assign offset = accum_in - u2u_pkg::SUPP_BASE;

   always_comb begin
      bytes_left_in   = bytes_left_ff;
      accum_in        = accum_ff;
      discarding_in   = discarding_ff;
      job_valid       = 1'b0;
      job.status      = u2u_pkg::STATUS_UNIT;
      job.pair        = 1'b0;
      job.unit_first  = '0;
      job.unit_second = '0;

      if (discarding_ff) begin
         if (in_byte == 8'h00) begin
            discarding_in = 1'b0;
         end
      end else if (bytes_left_ff != 2'd0) begin
         if (in_byte[7:6] == 2'b10) begin
            accum_in      = {accum_ff[14:0], in_byte[5:0]};
            bytes_left_in = bytes_left_ff - 2'd1;
            if (bytes_left_ff == 2'd1) begin
               job_valid = 1'b1;
               if (|accum_in[20:16]) begin
                  job.pair        = 1'b1;
                  job.unit_first  = u2u_pkg::SURR_HIGH | {6'd0, offset[19:10]};
                  job.unit_second = u2u_pkg::SURR_LOW | {6'd0, offset[9:0]};
               end else begin
                  job.unit_first = accum_in[15:0];
               end
            end
         end else begin
            bytes_left_in = 2'd0;
            accum_in      = '0;
            discarding_in = (in_byte != 8'h00);
            job_valid     = 1'b1;
            job.status    = u2u_pkg::STATUS_ERR;
         end
      end else if (in_byte == 8'h00) begin
         job_valid  = 1'b1;
         job.status = u2u_pkg::STATUS_END;
      end else if (in_byte < u2u_pkg::BYTE_CONT_BASE) begin
         job_valid      = 1'b1;
         job.unit_first = {8'd0, in_byte};
      end else if (in_byte < u2u_pkg::BYTE_LEAD2 || in_byte >= u2u_pkg::BYTE_ILLEGAL) begin
         discarding_in = 1'b1;
         job_valid     = 1'b1;
         job.status    = u2u_pkg::STATUS_ERR;
      end else if (in_byte < u2u_pkg::BYTE_LEAD3) begin
         accum_in      = {16'd0, in_byte[4:0]};
         bytes_left_in = 2'd1;
      end else if (in_byte < u2u_pkg::BYTE_LEAD4) begin
         accum_in      = {17'd0, in_byte[3:0]};
         bytes_left_in = 2'd2;
      end else begin
         accum_in      = {18'd0, in_byte[2:0]};
         bytes_left_in = 2'd3;
      end
   end

endmodule

// ----- hdl/u2u_fifo.sv -----
// Job queue between decode front end and output back end of the
// utf8_to_utf16_decoder. Uses u2u_pkg and the shared assertion macros.
`include "utf8_to_utf16_decoder_macros.svh"

module u2u_fifo #(
   parameter int Depth = u2u_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  u2u_pkg::job_type wr_job,
   output logic             full,
   input  logic             rd_en,
   output logic             rd_valid,
   output u2u_pkg::job_type rd_job
);

   localparam int AddrWidth  = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CountWidth = $clog2(Depth + 1);

   u2u_pkg::job_type       mem_ff [Depth];
   logic [AddrWidth-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CountWidth-1:0]  count_ff;

   function automatic logic [AddrWidth-1:0] next_ptr(input logic [AddrWidth-1:0] ptr);
      next_ptr = (ptr == AddrWidth'(Depth - 1)) ? '0 : ptr + 1'b1;
   endfunction

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (wr_en) wr_ptr_ff <= next_ptr(wr_ptr_ff);
         if (rd_en) rd_ptr_ff <= next_ptr(rd_ptr_ff);
         if (wr_en && !rd_en) begin
            count_ff <= count_ff + 1'b1;
         end else if (rd_en && !wr_en) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   assign full     = (count_ff == CountWidth'(Depth));
   assign rd_valid = (count_ff != '0);
   assign rd_job   = mem_ff[rd_ptr_ff];

   `U2U_ASSERT_IMPLIES(a_no_overflow, clock, reset, wr_en, !full)
   `U2U_ASSERT_IMPLIES(a_no_underflow, clock, reset, rd_en, rd_valid)
   `U2U_ASSERT_NEXT(a_count_grows, clock, reset, wr_en && !rd_en, count_ff == $past(count_ff) + 1'b1)

endmodule

// ----- hdl/u2u_back.sv -----
// Output back end of the utf8_to_utf16_decoder: expands queued jobs into
// result transactions through an output register. Uses u2u_pkg and macros.
`include "utf8_to_utf16_decoder_macros.svh"

module u2u_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   input  u2u_pkg::job_type job,
   output logic             job_take,
   output logic [15:0]      code_unit,
   output logic [1:0]       status,
   output logic             last_of_run,
   output logic             empty,
   input  logic             pop
);

   logic        out_valid_ff, out_valid_in;
   logic        phase_ff, phase_in;
   logic [15:0] unit_ff, unit_in;
   logic [1:0]  status_ff, status_in;
   logic        last_ff, last_in;
   logic        load;

   assign load = !out_valid_ff || pop;

   always_comb begin
      out_valid_in = out_valid_ff;
      phase_in     = phase_ff;
      unit_in      = unit_ff;
      status_in    = status_ff;
      last_in      = last_ff;
      job_take     = 1'b0;
      if (load) begin
         out_valid_in = job_valid;
         if (job_valid) begin
            status_in = job.status;
            if (job.pair && !phase_ff) begin
               unit_in  = job.unit_first;
               last_in  = 1'b0;
               phase_in = 1'b1;
            end else if (job.pair) begin
               unit_in  = job.unit_second;
               last_in  = 1'b1;
               phase_in = 1'b0;
               job_take = 1'b1;
            end else begin
               unit_in  = job.unit_first;
               last_in  = 1'b1;
               job_take = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         phase_ff     <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         phase_ff     <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      unit_ff   <= unit_in;
      status_ff <= status_in;
      last_ff   <= last_in;
   end

   assign code_unit   = unit_ff;
   assign status      = status_ff;
   assign last_of_run = last_ff;
   assign empty       = !out_valid_ff;

   `U2U_ASSERT_IMPLIES(a_pair_half_held, clock, reset, phase_ff, out_valid_ff && !last_ff && job_valid)
   `U2U_ASSERT_IMPLIES(a_non_unit_last, clock, reset, out_valid_ff && status_ff != u2u_pkg::STATUS_UNIT, last_ff)

endmodule

// ----- hdl/utf8_to_utf16_decoder.sv -----
// Top level of the UTF-8 to UTF-16 stream decoder.
// Instantiates u2u_front, u2u_fifo and u2u_back; uses u2u_pkg.
//
// Usage:
//   Input queue: drive req_in_byte and raise push; the byte is taken at a
//   clock edge where push is high and full is low. A zero byte ends a string.
//   Result queue: while empty is low the oldest result sits on rsp_code_unit,
//   rsp_status and rsp_last_of_run; it is taken at an edge with pop high.
//   rsp_status: 0 code unit, 1 clean end of string, 2 illegal sequence.
//   After an error, bytes up to and including the next zero give no result.
// Timing:
//   A byte's first result is written into the job queue, then loaded into the output register.
//   One byte per cycle is taken while full is low; one result per cycle is delivered while pop stays high.
//   A supplementary code point gives two results,
//   first the high surrogate (last_of_run low), then the low surrogate.
//   A QueueDepth-entry job queue between decode and output absorbs stalls;
//   when the consumer stops popping the queue fills and full rises.
// Reset: synchronous, active high; clears the decode state, the queue and
//   the output valid flag, so empty is high after reset.
module utf8_to_utf16_decoder #(
   parameter int QueueDepth = u2u_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [7:0]  req_in_byte,
   input  logic        push,
   output logic        full,
   output logic [15:0] rsp_code_unit,
   output logic [1:0]  rsp_status,
   output logic        rsp_last_of_run,
   output logic        empty,
   input  logic        pop
);

   logic             accept;
   logic             front_valid;
   u2u_pkg::job_type front_job;
   logic             head_valid;
   u2u_pkg::job_type head_job;
   logic             head_take;

   assign accept = push && !full;

   u2u_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .in_byte   (req_in_byte),
      .job_valid (front_valid),
      .job       (front_job)
   );

   u2u_fifo #(
      .Depth (QueueDepth)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (accept && front_valid),
      .wr_job   (front_job),
      .full     (full),
      .rd_en    (head_take),
      .rd_valid (head_valid),
      .rd_job   (head_job)
   );

   u2u_back u_back (
      .clock       (clock),
      .reset       (reset),
      .job_valid   (head_valid),
      .job         (head_job),
      .job_take    (head_take),
      .code_unit   (rsp_code_unit),
      .status      (rsp_status),
      .last_of_run (rsp_last_of_run),
      .empty       (empty),
      .pop         (pop)
   );

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for utf8_to_utf16_decoder: UTF-8 byte strings go in,
// and each UTF-16 result transaction is checked against an in-bench decoder.
// Depends on u2u_pkg and the utf8_to_utf16_decoder RTL.
module tb;

   localparam int RANDOM_BYTES = 1020;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int DRAIN_CYCLES = 20;
   localparam int HOLD_CYCLES  = 120;

   typedef struct {
      logic [15:0]         unit;
      u2u_pkg::status_type status;
      logic                last;
   } utf16_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic [7:0]  req_in_byte = 8'h00;
   logic        push = 1'b0;
   logic        full;
   logic [15:0] rsp_code_unit;
   logic [1:0]  rsp_status;
   logic        rsp_last_of_run;
   logic        empty;
   logic        pop = 1'b0;

   // decoder state of the predictor
   logic [1:0]  seq_left = 2'd0;
   logic [20:0] code_acc = 21'd0;
   bit          dropping = 1'b0;

   logic [7:0]       byte_stream[$];
   utf16_result_type expected_units[$];

   logic [7:0] directed_bytes[$] = '{
      8'h00,                               // empty string
      8'h01, 8'h7F,                        // ASCII extremes
      8'hC2, 8'h80, 8'hDF, 8'hBF,          // two-byte forms
      8'hEF, 8'hBF, 8'hBF,                 // three-byte top
      8'hF0, 8'h90, 8'h80, 8'h80,          // first supplementary, pair
      8'hF7, 8'hBF, 8'hBF, 8'hBF, 8'h00,   // beyond 10FFFF, still a pair
      8'h80, 8'h00,                        // stray continuation
      8'hFF, 8'h00,                        // illegal lead
      8'hC3, 8'h41, 8'h00,                 // bad continuation
      8'hE2, 8'h82, 8'h00                  // zero inside a sequence
   };

   int stream_items;
   int total_bytes;
   int bytes_sent;
   int results_checked;
   int pairs_seen;
   int ends_seen;
   int errors_seen;
   int stall_edges;
   int mismatches;
   int cycle_count;
   int hold_left;
   bit hold_done;

   utf8_to_utf16_decoder i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_in_byte     (req_in_byte),
      .push            (push),
      .full            (full),
      .rsp_code_unit   (rsp_code_unit),
      .rsp_status      (rsp_status),
      .rsp_last_of_run (rsp_last_of_run),
      .empty           (empty),
      .pop             (pop)
   );

   always #5 clock = ~clock;

   function automatic void expect_result(logic [15:0] unit, u2u_pkg::status_type st,
                                         logic last);
      utf16_result_type r;
      r.unit   = unit;
      r.status = st;
      r.last   = last;
      expected_units.insert(expected_units.size(), r);
   endfunction

   function automatic void expect_code_point(logic [20:0] cp);
      logic [20:0] m;
      if (cp >= u2u_pkg::SUPP_BASE) begin
         m = cp - u2u_pkg::SUPP_BASE;
         expect_result(u2u_pkg::SURR_HIGH | {6'd0, m[19:10]}, u2u_pkg::STATUS_UNIT, 1'b0);
         expect_result(u2u_pkg::SURR_LOW | {6'd0, m[9:0]}, u2u_pkg::STATUS_UNIT, 1'b1);
      end else begin
         expect_result(cp[15:0], u2u_pkg::STATUS_UNIT, 1'b1);
      end
   endfunction

   function automatic void decode_byte(logic [7:0] b);
      if (dropping) begin
         if (b == 8'h00) dropping = 1'b0;
         return;
      end
      if (seq_left != 2'd0) begin
         if (b >= u2u_pkg::BYTE_CONT_BASE && b < u2u_pkg::BYTE_LEAD2) begin
            code_acc = {code_acc[14:0], b[5:0]};
            seq_left = seq_left - 2'd1;
            if (seq_left == 2'd0) expect_code_point(code_acc);
            return;
         end
         seq_left = 2'd0;
         code_acc = 21'd0;
         if (b != 8'h00) dropping = 1'b1;
         expect_result(16'h0000, u2u_pkg::STATUS_ERR, 1'b1);
         return;
      end
      if (b == 8'h00) begin
         expect_result(16'h0000, u2u_pkg::STATUS_END, 1'b1);
      end else if (b < u2u_pkg::BYTE_CONT_BASE) begin
         expect_result({8'h00, b}, u2u_pkg::STATUS_UNIT, 1'b1);
      end else if (b < u2u_pkg::BYTE_LEAD2 || b >= u2u_pkg::BYTE_ILLEGAL) begin
         dropping = 1'b1;
         expect_result(16'h0000, u2u_pkg::STATUS_ERR, 1'b1);
      end else if (b < u2u_pkg::BYTE_LEAD3) begin
         code_acc = {16'd0, b[4:0]};
         seq_left = 2'd1;
      end else if (b < u2u_pkg::BYTE_LEAD4) begin
         code_acc = {17'd0, b[3:0]};
         seq_left = 2'd2;
      end else begin
         code_acc = {18'd0, b[2:0]};
         seq_left = 2'd3;
      end
   endfunction

   // stimulus generation
   function automatic void queue_byte(logic [7:0] b, bit counted);
      byte_stream.insert(byte_stream.size(), b);
      if (counted) stream_items++;
   endfunction

   function automatic void queue_lead(int conts);
      case (conts)
         1: queue_byte(u2u_pkg::BYTE_LEAD2 | 8'($urandom_range(31)), 1'b1);
         2: queue_byte(u2u_pkg::BYTE_LEAD3 | 8'($urandom_range(15)), 1'b1);
         default: queue_byte(u2u_pkg::BYTE_LEAD4 | 8'($urandom_range(7)), 1'b1);
      endcase
   endfunction

   function automatic void queue_cont();
      queue_byte(u2u_pkg::BYTE_CONT_BASE | 8'($urandom_range(63)), 1'b1);
   endfunction

   function automatic void queue_char();
      int r;
      int n;
      r = $urandom_range(9);
      if (r < 4) begin
         queue_byte(8'($urandom_range(1, 127)), 1'b1);
      end else begin
         n = (r < 6) ? 1 : (r < 8) ? 2 : 3;
         queue_lead(n);
         repeat (n) queue_cont();
      end
   endfunction

   // nonzero and outside 80-BF
   function automatic logic [7:0] bad_cont_byte();
      int v;
      v = $urandom_range(1, 191);
      return (v < 128) ? 8'(v) : 8'(v + 64);
   endfunction

   function automatic void queue_random_string();
      int n_chars;
      int fault_at;
      int kind;
      int n;
      int k;
      bit broken;
      n_chars  = $urandom_range(8);
      broken   = ($urandom_range(99) < 15);
      fault_at = $urandom_range(n_chars);
      for (int i = 0; i <= n_chars; i++) begin
         if (broken && i == fault_at) begin
            kind = $urandom_range(3);
            case (kind)
               0: queue_cont();
               1: queue_byte(u2u_pkg::BYTE_ILLEGAL | 8'($urandom_range(7)), 1'b1);
               default: begin
                  n = $urandom_range(1, 3);
                  k = $urandom_range(n - 1);
                  queue_lead(n);
                  repeat (k) queue_cont();
                  if (kind == 3) begin
                     queue_byte(8'h00, 1'b1);
                     return;
                  end
                  queue_byte(bad_cont_byte(), 1'b1);
               end
            endcase
            // dropped up to and including the terminator
            repeat ($urandom_range(3)) queue_byte(8'($urandom_range(1, 255)), 1'b0);
            queue_byte(8'h00, 1'b0);
            return;
         end
         if (i < n_chars) queue_char();
      end
      queue_byte(8'h00, 1'b1);
   endfunction

   function automatic int traffic_phase();
      return (bytes_sent * 3) / total_bytes;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else begin
         if (push && !full) begin
            decode_byte(req_in_byte);
            void'(byte_stream.pop_front());
            bytes_sent++;
         end
         if (push && full) begin
            stall_edges++;
         end else if (byte_stream.size() != 0 &&
                      $urandom_range(99) >= ((traffic_phase() == 0) ? 25 :
                                             (traffic_phase() == 1) ? 78 : 0)) begin
            push        <= 1'b1;
            req_in_byte <= byte_stream[0];
         end else begin
            push <= 1'b0;
         end
      end
   end

   // long hold-off on the result side
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (!hold_done && bytes_sent >= (total_bytes * 5) / 6) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   function automatic void check_result();
      utf16_result_type want;
      if (expected_units.size() == 0) begin
         mismatches++;
         $display("%0t: expected no transaction, actual unit=%h status=%0d last=%0d", $time,
                  rsp_code_unit, rsp_status, rsp_last_of_run);
         return;
      end
      want = expected_units.pop_front();
      results_checked++;
      if (want.status == u2u_pkg::STATUS_END) ends_seen++;
      if (want.status == u2u_pkg::STATUS_ERR) errors_seen++;
      if (want.status == u2u_pkg::STATUS_UNIT && !want.last) pairs_seen++;
      if (rsp_code_unit !== want.unit) begin
         mismatches++;
         $display("%0t: code_unit expected %h actual %h", $time, want.unit, rsp_code_unit);
      end
      if (rsp_status !== want.status) begin
         mismatches++;
         $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_status);
      end
      if (rsp_last_of_run !== want.last) begin
         mismatches++;
         $display("%0t: last_of_run expected %0d actual %0d", $time, want.last,
                  rsp_last_of_run);
      end
   endfunction

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) check_result();
         pop <= (hold_left == 0) &&
                ($urandom_range(99) >= ((traffic_phase() == 0) ? 78 :
                                        (traffic_phase() == 1) ? 25 : 0));
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("utf8_to_utf16_decoder verification failed");
         $finish;
      end
   end

   initial begin
      foreach (directed_bytes[i]) queue_byte(directed_bytes[i], 1'b1);
      while (stream_items < RANDOM_BYTES + directed_bytes.size()) queue_random_string();
      total_bytes = byte_stream.size();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      while (byte_stream.size() != 0 || push) @(posedge clock);
      while (expected_units.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d bytes (%0d directed); checked %0d transactions:",
               total_bytes, directed_bytes.size(), results_checked);
      $display("%0d pairs, %0d ends, %0d errors; input held off by full on %0d edges.",
               pairs_seen, ends_seen, errors_seen, stall_edges);
      if (mismatches == 0) begin
         $display("utf8_to_utf16_decoder verification clean");
      end else begin
         $display("utf8_to_utf16_decoder verification failed");
      end
      $finish;
   end

endmodule
